/* rtl/core/vrrq_pkg.sv */
// ----------------------------------------------------------------------------
// vrrq_pkg
// Shared types and codes for the variable-length record ring queue.
// ----------------------------------------------------------------------------
package vrrq_pkg;

  localparam int RING_BYTES_DEFAULT = 65536;
  localparam int HDR_BYTES = 16;
  localparam int HDR_W = 49;

  localparam logic [1:0] CMD_POST    = 2'd0;
  localparam logic [1:0] CMD_CONSUME = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NEVER = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] record_tag;
    logic [15:0] payload_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [15:0] out_payload_bytes;
    logic [15:0] payload_offset;
    logic [16:0] record_stride;
    logic        wrap_flag;
    logic [16:0] queued_bytes;
    logic [16:0] peak_bytes;
  } rsp_t;

endpackage

/* rtl/core/variable_record_ring_queue_top.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_queue_top
// Space manager for a ring of variable-length records with 16-byte headers.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  request | req_valid / req_ready | req (cmd, record_tag, payload_bytes)
//  result  | rsp_valid / rsp_ready | rsp (status, tag, length, offset, ...)
//
//  An item is accepted with its header read, then executed and written.
//  A post that lays down a wrap marker adds a wrap step, since the header memory
//  has one write port and the marker and the record go in on separate cycles.
//  Reset clears state, positions, peak fill and result valid only; the header
//  memory is not cleared, so the block is ready the cycle after reset.
//  The execute cycle waits while an earlier result is still not taken.
// ----------------------------------------------------------------------------
module variable_record_ring_queue_top #(
  parameter int RING_BYTES = vrrq_pkg::RING_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  vrrq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output vrrq_pkg::rsp_t rsp
);

  localparam int OFS_W  = $clog2(RING_BYTES);
  localparam int POS_W  = OFS_W + 1;
  localparam int SLOT_W = OFS_W - 4;
  localparam int SLOTS  = RING_BYTES / vrrq_pkg::HDR_BYTES;
  localparam int CW     = ((POS_W > 18) ? POS_W : 18) + 1;
  localparam logic [CW-1:0] RING_C = CW'(RING_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WRAP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [POS_W-1:0] wr_pos, wr_pos_next;
  logic [POS_W-1:0] rd_pos, rd_pos_next;
  logic [POS_W-1:0] peak, peak_next;
  vrrq_pkg::req_t   cur;
  logic [vrrq_pkg::HDR_W-1:0] hdr_rd;
  logic [vrrq_pkg::HDR_W-1:0] hdr_pend, hdr_pend_next;
  vrrq_pkg::rsp_t   res;

  logic [vrrq_pkg::HDR_W-1:0] hdr_mem [SLOTS];
  logic                       mem_we;
  logic [SLOT_W-1:0]          mem_waddr;
  logic [vrrq_pkg::HDR_W-1:0] mem_wdata;

  logic             accept;
  logic             exec_go;
  logic [POS_W-1:0] queued_cur;
  logic [POS_W-1:0] queued_next;
  logic [POS_W-1:0] q_post;
  logic [OFS_W-1:0] wr_off;
  logic [OFS_W-1:0] rd_off;
  logic [CW-1:0]    stride;
  logic [CW-1:0]    gap;
  logic [CW-1:0]    required;
  logic [CW-1:0]    free_b;
  logic [POS_W-1:0] wr_pos_post;
  logic [OFS_W-1:0] pofs_post;
  logic [OFS_W-1:0] pofs_cons;
  logic [16:0]      c_stride;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  assign queued_cur  = wr_pos - rd_pos;
  assign queued_next = wr_pos_next - rd_pos_next;
  assign wr_off      = wr_pos[OFS_W-1:0];
  assign rd_off      = rd_pos[OFS_W-1:0];
  assign stride      = CW'(({1'b0, cur.payload_bytes} + 17'd31) & ~17'd15);
  assign gap         = ((CW'(wr_off) + stride) > RING_C) ? (RING_C - CW'(wr_off)) : '0;
  assign required    = stride + gap;
  assign free_b      = RING_C - CW'(queued_cur);
  assign wr_pos_post = wr_pos + POS_W'(gap) + POS_W'(stride);
  assign q_post      = wr_pos_post - rd_pos;
  assign pofs_post   = ((gap != '0) ? '0 : wr_off) + OFS_W'(vrrq_pkg::HDR_BYTES);
  assign pofs_cons   = rd_off + OFS_W'(vrrq_pkg::HDR_BYTES);
  assign c_stride    = hdr_rd[48:32];

  always_comb begin
    res           = '0;
    wr_pos_next   = wr_pos;
    rd_pos_next   = rd_pos;
    peak_next     = peak;
    hdr_pend_next = hdr_pend;
    state_next    = state;
    mem_we        = 1'b0;
    mem_waddr     = wr_off[OFS_W-1:4];
    mem_wdata     = {17'(stride), cur.payload_bytes, cur.record_tag};
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
          case (cur.cmd)
            vrrq_pkg::CMD_POST: begin
              res.out_tag           = cur.record_tag;
              res.out_payload_bytes = cur.payload_bytes;
              res.record_stride     = 17'(stride);
              if (required > RING_C) begin
                res.status = vrrq_pkg::ST_NEVER;
              end else if (free_b < required) begin
                res.status = vrrq_pkg::ST_FULL;
              end else begin
                res.status         = vrrq_pkg::ST_OK;
                res.payload_offset = 16'(pofs_post);
                res.wrap_flag      = (gap != '0);
                wr_pos_next        = wr_pos_post;
                if (q_post > peak) begin
                  peak_next = q_post;
                end
                mem_we = 1'b1;
                if (gap != '0) begin
                  mem_wdata     = {17'(gap), 16'd0, 16'd0};
                  hdr_pend_next = {17'(stride), cur.payload_bytes, cur.record_tag};
                  state_next    = S_WRAP;
                end
              end
            end
            vrrq_pkg::CMD_CONSUME: begin
              if (queued_cur == '0) begin
                res.status = vrrq_pkg::ST_EMPTY;
              end else begin
                res.status            = vrrq_pkg::ST_OK;
                res.out_tag           = hdr_rd[15:0];
                res.out_payload_bytes = hdr_rd[31:16];
                res.payload_offset    = 16'(pofs_cons);
                res.record_stride     = c_stride;
                res.wrap_flag         = (hdr_rd[15:0] == 16'd0);
                rd_pos_next           = rd_pos + POS_W'(c_stride);
              end
            end
            vrrq_pkg::CMD_CLEAR: begin
              peak_next = '0;
            end
            default: begin
            end
          endcase
          res.queued_bytes = 17'(CW'(queued_next));
          res.peak_bytes   = 17'(CW'(peak_next));
        end
      end
      S_WRAP: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = hdr_pend;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      hdr_rd <= hdr_mem[rd_off[OFS_W-1:4]];
      cur    <= req;
    end
    if (exec_go) begin
      rsp <= res;
    end
    hdr_pend <= hdr_pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_pos    <= '0;
      rd_pos    <= '0;
      peak      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
      peak   <= peak_next;
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(queued_cur) <= RING_C)
    else $error("ring fill exceeds ring size");

  a_pos_aligned: assert property (@(posedge clk) disable iff (rst)
    wr_pos[3:0] == 4'd0 && rd_pos[3:0] == 4'd0)
    else $error("ring position off header alignment");

  a_wrap_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_WRAP |-> $past(state) == S_EXEC)
    else $error("wrap write without a post");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_EXEC)
    else $error("result appeared outside execute");

  a_wrap_flag_post: assert property (@(posedge clk) disable iff (rst)
    exec_go && state_next == S_WRAP |=> rsp.wrap_flag && rsp.status == vrrq_pkg::ST_OK)
    else $error("wrap marker written but not flagged");

endmodule

/* tb/variable_record_ring_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_queue_top_tb
// Drives post, consume, clear and unused command codes into the record ring queue under
// random stalls on both channels. A local ring accounting model predicts
// every result item, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module variable_record_ring_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING = 65536;
  localparam int unsigned OFS_MASK = RING - 1;
  localparam int unsigned POS_MASK = 2 * RING - 1;
  localparam int unsigned SLOTS = RING / vrrq_pkg::HDR_BYTES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [15:0] tag;
    logic [15:0] len;
    logic [16:0] stride;
  } slot_hdr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  vrrq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  vrrq_pkg::rsp_t rsp;

  slot_hdr_t      slot_hdr [SLOTS];
  int unsigned    wr_pos = 0;
  int unsigned    rd_pos = 0;
  int unsigned    peak_fill = 0;
  vrrq_pkg::rsp_t ring_outcome_q [$];
  vrrq_pkg::rsp_t rsp_want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_rsp_cycles = 0;
  int mismatch_count = 0;
  int n_items = 0;
  int n_placed = 0;
  int n_wraps = 0;
  int n_full = 0;
  int n_never = 0;
  int n_empty = 0;

  variable_record_ring_queue_top #(.RING_BYTES(RING)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic vrrq_pkg::rsp_t ring_outcome(vrrq_pkg::req_t r);
    int unsigned stride, ofs, gap, fill;
    slot_hdr_t h;
    vrrq_pkg::rsp_t o;
    o = '0;
    fill = (wr_pos - rd_pos) & POS_MASK;
    case (r.cmd)
      vrrq_pkg::CMD_POST: begin
        stride = (32'd31 + r.payload_bytes) & ~32'd15;
        ofs = wr_pos & OFS_MASK;
        gap = (ofs + stride > RING) ? RING - ofs : 0;
        o.out_tag = r.record_tag;
        o.out_payload_bytes = r.payload_bytes;
        o.record_stride = 17'(stride);
        if (stride + gap > RING) begin
          o.status = vrrq_pkg::ST_NEVER;
        end else if (RING - fill < stride + gap) begin
          o.status = vrrq_pkg::ST_FULL;
        end else begin
          if (gap != 0) begin
            slot_hdr[ofs >> 4] = '{16'd0, 16'd0, 17'(gap)};
            wr_pos = (wr_pos + gap) & POS_MASK;
            ofs = 0;
          end
          slot_hdr[ofs >> 4] = '{r.record_tag, r.payload_bytes, 17'(stride)};
          wr_pos = (wr_pos + stride) & POS_MASK;
          fill = (wr_pos - rd_pos) & POS_MASK;
          if (fill > peak_fill) peak_fill = fill;
          o.status = vrrq_pkg::ST_OK;
          o.payload_offset = 16'((ofs + 16) & OFS_MASK);
          o.wrap_flag = (gap != 0);
        end
      end
      vrrq_pkg::CMD_CONSUME: begin
        if (fill == 0) begin
          o.status = vrrq_pkg::ST_EMPTY;
        end else begin
          ofs = rd_pos & OFS_MASK;
          h = slot_hdr[ofs >> 4];
          rd_pos = (rd_pos + h.stride) & POS_MASK;
          o.status = vrrq_pkg::ST_OK;
          o.out_tag = h.tag;
          o.out_payload_bytes = h.len;
          o.payload_offset = 16'((ofs + 16) & OFS_MASK);
          o.record_stride = h.stride;
          o.wrap_flag = (h.tag == 16'd0);
        end
      end
      vrrq_pkg::CMD_CLEAR: peak_fill = 0;
      default: ;
    endcase
    o.queued_bytes = 17'((wr_pos - rd_pos) & POS_MASK);
    o.peak_bytes = 17'(peak_fill);
    return o;
  endfunction

  function automatic vrrq_pkg::req_t make_req(logic [1:0] c, logic [15:0] t,
                                               logic [15:0] l);
    vrrq_pkg::req_t r;
    r.cmd = c;
    r.record_tag = t;
    r.payload_bytes = l;
    return r;
  endfunction

  function automatic vrrq_pkg::req_t random_req(int post_pct);
    int k, c;
    vrrq_pkg::req_t r;
    k = $urandom_range(99);
    c = $urandom_range(99);
    if (c < post_pct) r.cmd = vrrq_pkg::CMD_POST;
    else if (c < 97) r.cmd = vrrq_pkg::CMD_CONSUME;
    else if (c < 99) r.cmd = vrrq_pkg::CMD_CLEAR;
    else r.cmd = CMD_UNUSED;
    r.record_tag = ($urandom_range(99) < 3) ? 16'd0 : 16'($urandom);
    if (k < 50) r.payload_bytes = 16'($urandom_range(255));
    else if (k < 85) r.payload_bytes = 16'($urandom_range(8191, 256));
    else if (k < 95) r.payload_bytes = 16'($urandom_range(40000, 8192));
    else r.payload_bytes = 16'($urandom_range(65535, 65000));
    return r;
  endfunction

  task automatic report_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns mismatch on %s: got %0h, want %0h", $time, name, got, want);
    end
  endtask

  task automatic send_item(vrrq_pkg::req_t item);
    vrrq_pkg::rsp_t o;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    o = ring_outcome(item);
    ring_outcome_q.push_back(o);
    n_items++;
    if (item.cmd == vrrq_pkg::CMD_POST && o.status == vrrq_pkg::ST_OK) n_placed++;
    if (item.cmd == vrrq_pkg::CMD_POST && o.wrap_flag) n_wraps++;
    if (o.status == vrrq_pkg::ST_FULL) n_full++;
    if (o.status == vrrq_pkg::ST_NEVER) n_never++;
    if (o.status == vrrq_pkg::ST_EMPTY) n_empty++;
  endtask

  task automatic wait_drain();
    @(negedge clk) req_valid <= 1'b0;
    while (ring_outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_rsp_cycles > 0) begin
      rsp_ready <= 1'b0;
      hold_rsp_cycles <= hold_rsp_cycles - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (ring_outcome_q.size() == 0) begin
        report_field("unexpected item", 32'd1, 32'd0);
      end else begin
        rsp_want = ring_outcome_q.pop_front();
        report_field("status", rsp.status, rsp_want.status);
        report_field("out_tag", rsp.out_tag, rsp_want.out_tag);
        report_field("out_payload_bytes", rsp.out_payload_bytes, rsp_want.out_payload_bytes);
        report_field("payload_offset", rsp.payload_offset, rsp_want.payload_offset);
        report_field("record_stride", rsp.record_stride, rsp_want.record_stride);
        report_field("wrap_flag", rsp.wrap_flag, rsp_want.wrap_flag);
        report_field("queued_bytes", rsp.queued_bytes, rsp_want.queued_bytes);
        report_field("peak_bytes", rsp.peak_bytes, rsp_want.peak_bytes);
      end
    end
  end

  task automatic test_edge_cases();
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h1234, 16'd7));
    send_item(make_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF));
    send_item(make_req(vrrq_pkg::CMD_CLEAR, 16'h0000, 16'h0000));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'hA5A5, 16'd65520));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'hFFFF, 16'd65535));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0001, 16'd1));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0002, 16'd65400));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0003, 16'd100));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0003, 16'd100));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0004, 16'd65392));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'hFFFF, 16'd65520));
    send_item(make_req(vrrq_pkg::CMD_POST, 16'h0005, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CLEAR, 16'h0000, 16'h0000));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    send_item(make_req(vrrq_pkg::CMD_CONSUME, 16'h0000, 16'd0));
    wait_drain();
  endtask

  task automatic test_random_traffic(int n, int post_pct);
    repeat (n) send_item(random_req(post_pct));
  endtask

  task automatic test_rsp_backpressure();
    send_idle_pct = 0;
    hold_rsp_cycles = 300;
    repeat (80) send_item(random_req(55));
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_edge_cases();
    send_idle_pct = 38;
    recv_idle_pct = 70;
    test_random_traffic(275, 70);
    test_random_traffic(275, 35);
    wait_drain();
    send_idle_pct = 70;
    recv_idle_pct = 38;
    test_random_traffic(275, 70);
    test_random_traffic(275, 35);
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(275, 70);
    test_random_traffic(275, 35);
    wait_drain();
    test_rsp_backpressure();
    $display("covered %0d items: %0d records placed, %0d wrap markers, %0d full retries,",
             n_items, n_placed, n_wraps, n_full);
    $display("%0d never-fit posts, %0d empty consumes, %0d field mismatches",
             n_never, n_empty, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d items outstanding", ring_outcome_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
